@@ rtl/core/eed_pkg.sv @@
`default_nettype none
package eed_pkg;

   // item kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_ARG_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ARG_BYTE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ARG_END   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EOL       = 2'd3;

   // escape phases
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_SLASH = 2'd1;
   localparam logic [1:0] PHASE_OCTAL = 2'd2;

   // register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEWLINE_OFF = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPES_ON  = 1'd1;

   // character codes
   localparam logic [7:0] CH_BEL       = 8'd7;
   localparam logic [7:0] CH_BS        = 8'd8;
   localparam logic [7:0] CH_FF        = 8'd12;
   localparam logic [7:0] CH_NL        = 8'h0a;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_EIGHT     = 8'h38;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_C         = 8'h63;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_T         = 8'h74;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/core/echo_escape_decoder.sv @@
`default_nettype none
// Echo decoder with a subset of System V backslash escapes. Each input item is
// one token of a command line (argument start, argument byte, argument end,
// end of line) and gives zero, one or two output bytes, the final one flagged
// by rsp_last. Items are decoded in the cycle they are accepted, one per cycle,
// and their results go into a four-entry result queue that delivers one byte
// per cycle while rsp_stall is low; req_stall rises while fewer than two queue
// entries are free, so the sustained rate is one item per cycle as long as the
// output drains the bytes produced. Register writes are taken at once (csr_ready
// is always high) and must only happen while the block is idle.
module echo_escape_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [eed_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [7:0]                     req_in_byte,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [7:0]                     rsp_out_byte,
   output      logic                           rsp_last,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [eed_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic                           csr_data
);
   import eed_pkg::*;

   logic       newline_off_ff, escapes_on_ff;
   logic       started_ff, started_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] octal_ff, octal_in;
   logic       stop_ff, stop_in;

   result_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   logic       accept, pop;
   logic       oct_en, second_en;
   logic [7:0] second_byte;
   logic [1:0] n_push;
   result_type entry0, entry1;
   logic [QUEUE_PTR_W-1:0] wr_ptr_next;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff > QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_out_byte = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_last     = queue_ff[rd_ptr_ff].last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         newline_off_ff <= 1'b0;
         escapes_on_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NEWLINE_OFF) newline_off_ff <= csr_data;
         if (csr_index == CSR_ESCAPES_ON)  escapes_on_ff  <= csr_data;
      end
   end

   // token decode: an optional pending octal byte, then an optional second byte
   always_comb begin
      started_in  = started_ff;
      phase_in    = phase_ff;
      octal_in    = octal_ff;
      stop_in     = stop_ff;
      oct_en      = 1'b0;
      second_en   = 1'b0;
      second_byte = req_in_byte;
      case (req_kind)
         KIND_ARG_START: begin
            oct_en      = (phase_ff == PHASE_OCTAL);
            phase_in    = PHASE_IDLE;
            octal_in    = '0;
            second_en   = started_ff;
            second_byte = CH_SPACE;
            started_in  = 1'b1;
         end
         KIND_ARG_END: begin
            oct_en   = (phase_ff == PHASE_OCTAL);
            phase_in = PHASE_IDLE;
            octal_in = '0;
         end
         KIND_EOL: begin
            oct_en      = (phase_ff == PHASE_OCTAL);
            phase_in    = PHASE_IDLE;
            octal_in    = '0;
            second_en   = !newline_off_ff && !stop_ff;
            second_byte = CH_NL;
            started_in  = 1'b0;
            stop_in     = 1'b0;
         end
         KIND_ARG_BYTE: begin
            if (!escapes_on_ff) begin
               oct_en    = (phase_ff == PHASE_OCTAL);
               phase_in  = PHASE_IDLE;
               octal_in  = '0;
               second_en = 1'b1;
            end else if (phase_ff == PHASE_SLASH) begin
               phase_in  = PHASE_IDLE;
               second_en = 1'b1;
               case (req_in_byte)
                  CH_A:         second_byte = CH_BEL;
                  CH_B:         second_byte = CH_BS;
                  CH_F:         second_byte = CH_FF;
                  CH_N:         second_byte = CH_NL;
                  CH_T:         second_byte = CH_TAB;
                  CH_BACKSLASH: second_byte = CH_BACKSLASH;
                  CH_C: begin
                     second_en = 1'b0;
                     stop_in   = 1'b1;
                  end
                  CH_ZERO: begin
                     second_en = 1'b0;
                     octal_in  = '0;
                     phase_in  = PHASE_OCTAL;
                  end
                  default: second_en = 1'b0;
               endcase
            end else if (phase_ff == PHASE_OCTAL) begin
               if (req_in_byte >= CH_ZERO && req_in_byte < CH_EIGHT) begin
                  octal_in = {octal_ff[4:0], req_in_byte[2:0]};
               end else begin
                  oct_en    = 1'b1;
                  phase_in  = PHASE_IDLE;
                  octal_in  = '0;
                  second_en = 1'b1;
               end
            end else begin
               // idle, or the unused phase code
               if (req_in_byte == CH_BACKSLASH) begin
                  phase_in = PHASE_SLASH;
               end else begin
                  phase_in  = PHASE_IDLE;
                  second_en = 1'b1;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // pack up to two results, last flag on the final one
   always_comb begin
      n_push = 2'(oct_en) + 2'(second_en);
      if (oct_en) begin
         entry0.out_byte = octal_ff;
         entry0.last     = !second_en;
      end else begin
         entry0.out_byte = second_byte;
         entry0.last     = 1'b1;
      end
      entry1.out_byte = second_byte;
      entry1.last     = 1'b1;
      wr_ptr_next     = wr_ptr_ff + QUEUE_PTR_W'(1);
      count_in        = count_ff;
      if (accept) count_in = count_in + QUEUE_CNT_W'(n_push);
      if (pop)    count_in = count_in - QUEUE_CNT_W'(1);
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         phase_ff   <= PHASE_IDLE;
         octal_ff   <= '0;
         stop_ff    <= 1'b0;
      end else if (accept) begin
         started_ff <= started_in;
         phase_ff   <= phase_in;
         octal_ff   <= octal_in;
         stop_ff    <= stop_in;
      end
   end

   // result queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(n_push);
         if (pop)    rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (accept && (n_push != 2'd0)) queue_ff[wr_ptr_ff] <= entry0;
      if (accept && (n_push == 2'd2)) queue_ff[wr_ptr_next] <= entry1;
   end

endmodule
`default_nettype wire
